// ----- hw/rtl/bmf_pkg.sv -----
`default_nettype none

package bmf_pkg;

  // block length used when the top level is not given one
  localparam int unsigned WINDOW_DEFAULT = 11;

  // converter sample and result width
  localparam int unsigned SAMPLE_W = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // what one cell hands to its right-hand neighbor
  typedef struct packed {
    logic    ins;    // new sample goes at or left of this cell
    logic    valid;  // cell holds a sample of the current block
    sample_t value;  // held sample
  } link_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmf_if.sv -----
`default_nettype none

// converter sample channel
interface bmf_sample_if;
  import bmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// median result channel
interface bmf_median_if;
  import bmf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bmf_cell.sv -----
`default_nettype none

module bmf_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            clear,
  input  wire bmf_pkg::sample_t x,
  input  wire bmf_pkg::link_t  left,
  output bmf_pkg::link_t       right,
  output bmf_pkg::sample_t     ins_value
);
  import bmf_pkg::*;

  logic    valid;
  logic    valid_next;
  sample_t value;

  // insertion point: empty cell or held value above the new one
  assign right.ins   = !valid || (value > x);
  assign right.valid = valid;
  assign right.value = value;

  // shift in from the left, take the new sample, or keep
  always_comb begin
    priority if (left.ins) begin
      ins_value  = left.value;
      valid_next = left.valid;
    end else if (right.ins) begin
      ins_value  = x;
      valid_next = 1'b1;
    end else begin
      ins_value  = value;
      valid_next = valid;
    end
  end

  // occupancy, cleared when a block completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= clear ? 1'b0 : valid_next;
    end
  end

  // held sample
  always_ff @(posedge clk) begin
    if (load) begin
      value <= ins_value;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/block_median_filter_unit.sv -----
`default_nettype none

// The median of a block is registered on its last sample transfer and appears in the cycle after it.
// Throughput: one sample per cycle, but a block's last sample waits while the result is untaken;
// each sample is inserted into a sorted row of WINDOW cells, one result per WINDOW samples.
// A new block's last sample waits only while the previous median is still untaken.
// Reset: fill count, cell occupancy and result valid are cleared; no clearing pass.

module block_median_filter_unit #(
  parameter int unsigned WINDOW = bmf_pkg::WINDOW_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  bmf_sample_if.sink  adc,
  bmf_median_if.source result
);
  import bmf_pkg::*;

  localparam int unsigned CW  = $clog2(WINDOW);
  localparam int unsigned MID = (WINDOW - 1) / 2;

  logic [CW-1:0] fill_count;
  logic          last;
  logic          take;
  logic          out_valid;
  sample_t       out_median;
  link_t         links [WINDOW+1];
  sample_t       ins_values [WINDOW];
  logic [WINDOW-1:0] occupied;

  assign last = (fill_count == CW'(WINDOW - 1));

  // hold the block's last sample only while the result register is full and not taken
  assign adc.ready = !last || !out_valid || result.ready;
  assign take      = adc.valid && adc.ready;

  // left end of the row never shifts in
  assign links[0] = '{ins: 1'b0, valid: 1'b0, value: '0};

  // sorted row, ascending from cell 0
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    bmf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (take),
      .clear     (last),
      .x         (adc.sample),
      .left      (links[i]),
      .right     (links[i+1]),
      .ins_value (ins_values[i])
    );
    assign occupied[i] = links[i+1].valid;
  end

  // samples held in the current block
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (take) begin
      fill_count <= last ? '0 : fill_count + CW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      out_median <= ins_values[MID];
    end
  end

  assign result.valid  = out_valid;
  assign result.median = out_median;

  // occupied cells match the fill count in number and start at cell 0
  a_fill_matches: assert property (@(posedge clk) disable iff (rst)
    ($countones(occupied) == int'(fill_count)) && (occupied[0] || fill_count == '0))
    else $error("cell occupancy does not match fill count");

  // the row is empty and a result is valid after a block completes
  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    (take && last) |=> (occupied == '0) && out_valid)
    else $error("row not cleared or result missing after block end");

  // a result only follows a block-completing sample transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take && last))
    else $error("result raised without a completed block");

  // a pending result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(take && last))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire
